/* rtl/mpmv_pkg.sv */
// ----------------------------------------------------------------------------
// mpmv_pkg
// shared types and constants of the mixed precision matrix-vector engine
// ----------------------------------------------------------------------------
package mpmv_pkg;

    localparam int WsDepth = 16384;
    localparam int WsAw    = 14;

    typedef enum logic [1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_ACT    = 2'd1,
        REQ_COMP   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_I8I8 = 2'd0,
        MODE_I8I4 = 2'd1,
        MODE_I4I4 = 2'd2,
        MODE_BAD  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_IN   = 2'd1;
    localparam logic [1:0] CFG_OUT  = 2'd2;

    localparam logic [3:0] NIB_MASK = 4'h0F;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_WAIT = 2'd2
    } t_state;

    typedef struct packed {
        t_req        req;
        logic [13:0] addr;
        logic [7:0]  data;
    } t_cmd;

    function automatic logic signed [7:0] sx4(input logic [3:0] b);
        sx4 = {{4{b[3]}}, b};
    endfunction

endpackage

/* rtl/mpmv_ram.sv */
// ----------------------------------------------------------------------------
// mpmv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mpmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/mpmv_front.sv */
// ----------------------------------------------------------------------------
// mpmv_front
// input acceptance and a two entry command queue
// ----------------------------------------------------------------------------
module mpmv_front import mpmv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_cmd        i_cmd,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  logic        i_q_pop
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[0];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_q_pop) begin
            r_q[0] <= r_q[1];
        end
        if (push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_q_pop)) begin
                r_q[0] <= i_cmd;
            end else begin
                r_q[1] <= i_cmd;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop on empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_q_pop) |=> o_stall) else $error("full queue not stalled");
endmodule

/* rtl/mpmv_back.sv */
// ----------------------------------------------------------------------------
// mpmv_back
// store writes and the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module mpmv_back import mpmv_pkg::*; #(
    parameter int IN_MAX  = 256,
    parameter int OUT_MAX = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    input  t_mode              i_mode,
    input  logic [8:0]         i_in_count,
    input  logic [6:0]         i_out_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_out_index,
    output logic signed [23:0] o_dot_sum,
    output logic               o_last
);
    localparam int AAW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int KW  = $clog2(IN_MAX + 1);
    localparam int EW  = $clog2(IN_MAX * OUT_MAX + 1);

    t_state r_st, n_st;
    logic [KW-1:0]  r_k, r_n;
    logic [6:0]     r_j, r_m;
    logic [EW-1:0]  r_e;
    t_mode          r_mode;
    logic           r_p1v, r_p2v, r_p1last_k, r_p2last_k, r_ka, r_ea;
    logic [6:0]     r_p1j, r_p2j;
    logic signed [7:0]  r_a, r_w;
    logic signed [15:0] prod;
    logic [23:0]    r_acc;
    logic           r_ov;
    logic [5:0]     r_oidx;
    logic [23:0]    r_osum;
    logic           r_olast;
    logic [7:0]     act_q, w_q;
    logic           start, issue, is_comp, busy;
    logic [KW-1:0]  n_eff;
    logic [6:0]     m_eff;
    logic [AAW-1:0] a_raddr;
    logic [WsAw-1:0] w_raddr;
    logic [KW-1:0]  a_word;
    logic [EW-1:0]  w_word;

    assign is_comp = (i_q_cmd.req == REQ_COMP);
    assign n_eff = ({23'd0, i_in_count} > 32'(IN_MAX)) ? KW'(IN_MAX) : KW'(i_in_count);
    assign m_eff = (i_out_count > 7'(OUT_MAX)) ? 7'(OUT_MAX) : i_out_count;
    assign busy  = r_p1v || r_p2v || r_ov;
    assign prod  = r_a * r_w;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (i_q_valid && is_comp && i_mode != MODE_BAD && m_eff != 7'd0) begin
                    n_st = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue && r_k + KW'(1) >= r_n && r_j + 7'd1 == r_m) begin
                    n_st = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!busy) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // issue waits for a finished row to drain and its result to leave
    always_comb begin
        start   = (r_st == ST_IDLE) && i_q_valid && is_comp;
        o_q_pop = (r_st == ST_IDLE) && i_q_valid;
        issue   = (r_st == ST_RUN) && !r_ov && !(r_p1v && r_p1last_k)
                  && !(r_p2v && r_p2last_k);
    end

    assign a_word  = (r_mode == MODE_I4I4) ? (r_k >> 1) : r_k;
    assign w_word  = (r_mode == MODE_I8I8) ? r_e : (r_e >> 1);
    assign a_raddr = AAW'(a_word);
    assign w_raddr = WsAw'(w_word);

    mpmv_ram #(.WIDTH(8), .DEPTH(IN_MAX)) u_act (
        .i_clk(i_clk),
        .i_we(o_q_pop && i_q_cmd.req == REQ_ACT && {2'b0, i_q_cmd.addr} < 16'(IN_MAX)),
        .i_waddr(AAW'(i_q_cmd.addr)), .i_wdata(i_q_cmd.data),
        .i_raddr(a_raddr), .o_rdata(act_q)
    );
    mpmv_ram #(.WIDTH(8), .DEPTH(WsDepth)) u_wgt (
        .i_clk(i_clk),
        .i_we(o_q_pop && i_q_cmd.req == REQ_WEIGHT),
        .i_waddr(i_q_cmd.addr), .i_wdata(i_q_cmd.data),
        .i_raddr(w_raddr), .o_rdata(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_st <= n_st;
            r_p1v <= issue && r_n != KW'(0);
            r_p2v <= r_p1v;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if ((r_p2v && r_p2last_k) || (issue && r_n == KW'(0))) begin
                r_ov <= 1'b1;
            end
        end
        if (start) begin
            r_k <= '0;
            r_j <= '0;
            r_e <= '0;
            r_n <= n_eff;
            r_m <= m_eff;
            r_mode <= i_mode;
        end else if (issue) begin
            r_e <= r_e + EW'(1);
            if (r_k + KW'(1) >= r_n) begin
                r_k <= '0;
                r_j <= r_j + 7'd1;
            end else begin
                r_k <= r_k + KW'(1);
            end
        end
        r_p1last_k <= (r_k + KW'(1) >= r_n);
        r_p1j <= r_j;
        r_ka  <= r_k[0];
        r_ea  <= r_e[0];
        // stage 1: register the read data, selecting and sign-extending int4 nibbles
        case (r_mode)
            MODE_I8I8: begin r_a <= act_q; r_w <= w_q; end
            MODE_I8I4: begin
                r_a <= act_q;
                r_w <= sx4(r_ea ? w_q[7:4] : (w_q[3:0] & NIB_MASK));
            end
            default: begin
                r_a <= sx4(r_ka ? act_q[7:4] : act_q[3:0]);
                r_w <= sx4(r_ea ? w_q[7:4] : w_q[3:0]);
            end
        endcase
        r_p2last_k <= r_p1last_k;
        r_p2j <= r_p1j;
        // stage 2: multiply and accumulate
        if (start || (r_ov && !i_stall && r_p2last_k)) begin
            r_acc <= '0;
        end
        if (r_p2v) begin
            if (r_p2last_k) begin
                r_osum  <= r_acc + 24'(prod);
                r_oidx  <= r_p2j[5:0];
                r_olast <= (r_p2j + 7'd1 == r_m);
                r_acc   <= '0;
            end else begin
                r_acc <= r_acc + 24'(prod);
            end
        end else if (issue && r_n == KW'(0)) begin
            r_osum  <= '0;
            r_oidx  <= r_j[5:0];
            r_olast <= (r_j + 7'd1 == r_m);
        end
    end

    assign o_valid     = r_ov;
    assign o_out_index = r_oidx;
    assign o_dot_sum   = r_osum;
    assign o_last      = r_olast;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_osum))) else $error("result lost");
    a_no_issue_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !issue) else $error("issue with result pending");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == ST_IDLE) else $error("pop while busy");
endmodule

/* rtl/mixed_precision_matvec_engine.sv */
// ----------------------------------------------------------------------------
// mixed_precision_matvec_engine
// quantized int8/int4 matrix-vector engine with weight store and row buffer
// ----------------------------------------------------------------------------
// byte writes: one transaction per cycle, stalled while the two entry queue is full
// compute: one multiply-accumulate per cycle from the single weight store read
// port while no row drains and no result is pending; result stalls add time,
// each row drains the three stage pipe before its result; next queue item waits.
// first result: run state, read data, operand, result registers (n = 0: no reads)
// synchronous active-low reset sets control and config; data regs, stores stay unset
module mixed_precision_matvec_engine import mpmv_pkg::*; #(
    parameter int IN_MAX  = 256,
    parameter int OUT_MAX = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [13:0]        i_byte_index,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_out_index,
    output logic signed [23:0] o_dot_sum,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);
    t_mode      r_mode;
    logic [8:0] r_in;
    logic [6:0] r_out;
    t_cmd       cmd, q_cmd;
    logic       q_valid, q_pop;

    assign o_cfg_ready = 1'b1;
    assign cmd = '{req: t_req'(i_req_type), addr: i_byte_index, data: i_data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_I8I8;
            r_in   <= 9'd256;
            r_out  <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_IN:   r_in   <= i_cfg_data;
                CFG_OUT:  r_out  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mpmv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(cmd), .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    mpmv_back #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_cmd(q_cmd),
        .o_q_pop(q_pop), .i_mode(r_mode), .i_in_count(r_in), .i_out_count(r_out),
        .o_valid(o_valid), .i_stall(i_stall), .o_out_index(o_out_index),
        .o_dot_sum(o_dot_sum), .o_last(o_last)
    );
endmodule
